FILE: design/rlkd_pkg.sv
// Package for the resistor ladder key decoder: widths, register indexes,
// back end state type and the ladder level table. No dependencies.
package rlkd_pkg;

   // Parameter defaults
   localparam int SAMPLE_BITS_DEF = 10;
   localparam int KEY_LEVELS_DEF  = 32;

   // Fixed field widths
   localparam int COUNT_W  = 10;           // sample_count register
   localparam int POS_W    = COUNT_W + 1;  // window position, holds up to 1024
   localparam int THRESH_W = 8;
   localparam int TIME_W   = 32;
   localparam int KEY_W    = 5;
   localparam int AVG_W    = 10;
   localparam int LEVEL_W  = 12;           // a level at the widest sample width
   localparam int FIFO_DEPTH = 2;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = COUNT_W;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD    = 1'd1;

   // Back end sequencer
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_CLASS
   } back_state_type;

   // Ladder levels at 10 bits; entry 0 is the no-key level
   localparam logic [9:0] LADDER_LEVEL [32] = '{
      10'd983, 10'd968, 10'd944, 10'd931, 10'd908, 10'd895, 10'd876, 10'd865,
      10'd844, 10'd831, 10'd812, 10'd800, 10'd782, 10'd769, 10'd754, 10'd745,
      10'd727, 10'd712, 10'd692, 10'd681, 10'd660, 10'd648, 10'd632, 10'd621,
      10'd605, 10'd592, 10'd576, 10'd566, 10'd549, 10'd539, 10'd524, 10'd515
   };

   // Level of possibility k, shifted to a sample width of sb bits
   function automatic logic [LEVEL_W-1:0] scaled_level(input int k, input int sb);
      logic [LEVEL_W-1:0] base;
      base = LEVEL_W'(LADDER_LEVEL[k]);
      if (sb >= 10) begin
         return base << (sb - 10);
      end else begin
         return base >> (10 - sb);
      end
   endfunction

endpackage

FILE: design/rlkd_if.sv
// Channel interfaces of the resistor ladder key decoder: sample requests and
// key results. Depends on rlkd_pkg.
interface rlkd_req_if #(parameter int SAMPLE_BITS = rlkd_pkg::SAMPLE_BITS_DEF) ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   logic [31:0]            now_ms;

   modport source (output valid, sample, now_ms, input ready);
   modport sink   (input valid, sample, now_ms, output ready);
endinterface

interface rlkd_rsp_if ();
   logic        valid;
   logic        ready;
   logic [4:0]  key;
   logic        changed;
   logic [31:0] held_ms;
   logic [9:0]  average;

   modport source (output valid, key, changed, held_ms, average, input ready);
   modport sink   (input valid, key, changed, held_ms, average, output ready);
endinterface

FILE: design/rlkd_front.sv
// Front end: drops the settling sample, sums the window and hands the window
// sum, count and end time to the queue. Depends on rlkd_pkg.
module rlkd_front #(
   parameter int SAMPLE_BITS = rlkd_pkg::SAMPLE_BITS_DEF,
   parameter int SUM_W       = SAMPLE_BITS + rlkd_pkg::COUNT_W,
   parameter int ENTRY_W     = SUM_W + rlkd_pkg::POS_W + rlkd_pkg::TIME_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rlkd_pkg::COUNT_W-1:0] sample_count,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [SAMPLE_BITS-1:0]      in_sample,
   input  logic [rlkd_pkg::TIME_W-1:0] in_now,
   input  logic                        queue_full,
   output logic                        push,
   output logic [ENTRY_W-1:0]          push_data
);
   import rlkd_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             accept;
   logic [SUM_W-1:0] sum_next;
   logic             window_end;

   // Stall only while the queue has no room
   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   assign sum_next   = sum_ff + SUM_W'(in_sample);
   assign window_end = (pos_ff != '0) && (pos_ff > POS_W'(sample_count));

   // Hand a finished window to the queue
   assign push      = accept && window_end;
   assign push_data = {sum_next, pos_ff, in_now};

   // Advance the window position and the running sum
   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (accept) begin
         if (pos_ff == '0) begin
            pos_in = POS_W'(1);
            sum_in = '0;
         end else if (window_end) begin
            pos_in = '0;
            sum_in = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
            sum_in = sum_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

endmodule

FILE: design/rlkd_fifo.sv
// Short queue of finished windows between front and back end.
// Depends on rlkd_pkg.
module rlkd_fifo #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              full,
   output logic              empty
);
   import rlkd_pkg::*;

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full     = (count_ff == CNT_W'(FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the item
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("window queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("window queue read while empty");

endmodule

FILE: design/rlkd_back.sv
// Back end: serial divide of the window sum, change test, ladder match and
// the result register. Depends on rlkd_pkg.
module rlkd_back #(
   parameter int SAMPLE_BITS = rlkd_pkg::SAMPLE_BITS_DEF,
   parameter int KEY_LEVELS  = rlkd_pkg::KEY_LEVELS_DEF,
   parameter int SUM_W       = SAMPLE_BITS + rlkd_pkg::COUNT_W,
   parameter int ENTRY_W     = SUM_W + rlkd_pkg::POS_W + rlkd_pkg::TIME_W
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [rlkd_pkg::THRESH_W-1:0]  threshold,
   input  logic                           queue_empty,
   input  logic [ENTRY_W-1:0]             queue_data,
   output logic                           pop,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [rlkd_pkg::KEY_W-1:0]     out_key,
   output logic                           out_changed,
   output logic [rlkd_pkg::TIME_W-1:0]    out_held_ms,
   output logic [rlkd_pkg::AVG_W-1:0]     out_average
);
   import rlkd_pkg::*;

   localparam int BIT_W = $clog2(SUM_W);
   localparam int CMP_W = SAMPLE_BITS + 1;

   back_state_type state_ff, state_in;

   // Divider
   logic [SUM_W-1:0]  quo_ff;
   logic [POS_W-1:0]  rem_ff;
   logic [POS_W-1:0]  div_ff;
   logic [TIME_W-1:0] now_ff;
   logic [BIT_W-1:0]  bit_ff;
   logic [POS_W:0]    rem_shift;
   logic              rem_ge;

   // Tracking state
   logic [SAMPLE_BITS-1:0] prev_avg_ff;
   logic [KEY_W-1:0]       rep_key_ff;
   logic [TIME_W-1:0]      chg_time_ff;

   // Result register
   logic              valid_ff;
   logic [KEY_W-1:0]  key_ff;
   logic              changed_ff;
   logic [TIME_W-1:0] held_ff;
   logic [AVG_W-1:0]  avg_ff;

   // Sequencer controls
   logic load, step, finish, slot_free;

   // Classification
   logic [SAMPLE_BITS-1:0] avg;
   logic [CMP_W-1:0]       a_w, th_w, p_w;
   logic                   changed;
   logic                   no_key;
   logic                   hit_any;
   logic [KEY_W-1:0]       hit_key;
   logic [KEY_W-1:0]       new_key;
   logic [TIME_W-1:0]      new_time;

   assign slot_free = !valid_ff || out_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            if (bit_ff == '0) begin
               state_in = BK_CLASS;
            end
         end
         BK_CLASS: begin
            if (slot_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      load   = 1'b0;
      step   = 1'b0;
      finish = 1'b0;
      case (state_ff)
         BK_IDLE:  load   = !queue_empty;
         BK_DIV:   step   = 1'b1;
         BK_CLASS: finish = slot_free;
         default: begin
            load   = 1'b0;
            step   = 1'b0;
            finish = 1'b0;
         end
      endcase
   end

   assign pop = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // One quotient bit a cycle, restoring
   assign rem_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, div_ff});

   always_ff @(posedge clock) begin
      if (load) begin
         quo_ff <= queue_data[ENTRY_W-1 -: SUM_W];
         div_ff <= queue_data[TIME_W +: POS_W];
         now_ff <= queue_data[TIME_W-1:0];
         rem_ff <= '0;
         bit_ff <= BIT_W'(SUM_W - 1);
      end else if (step) begin
         quo_ff <= {quo_ff[SUM_W-2:0], rem_ge};
         rem_ff <= rem_ge ? POS_W'(rem_shift - {1'b0, div_ff}) : rem_shift[POS_W-1:0];
         bit_ff <= bit_ff - BIT_W'(1);
      end
   end

   // Change test against the previous average
   assign avg  = quo_ff[SAMPLE_BITS-1:0];
   assign a_w  = CMP_W'(avg);
   assign th_w = CMP_W'(threshold);
   assign p_w  = CMP_W'(prev_avg_ff);

   assign changed = !(((a_w + th_w) > p_w) && (a_w < (p_w + th_w)));
   assign no_key  = (a_w + th_w) > CMP_W'(scaled_level(0, SAMPLE_BITS));

   // First ladder level whose window holds the average
   always_comb begin
      hit_any = 1'b0;
      hit_key = '0;
      for (int k = KEY_LEVELS - 1; k >= 1; k--) begin
         logic [CMP_W-1:0] lvl;
         lvl = CMP_W'(scaled_level(k, SAMPLE_BITS));
         if (((a_w + th_w) > lvl) && (a_w < (lvl + th_w))) begin
            hit_any = 1'b1;
            hit_key = KEY_W'(k);
         end
      end
   end

   // Hold the last key when nothing matches
   always_comb begin
      new_key  = rep_key_ff;
      new_time = chg_time_ff;
      if (changed) begin
         new_time = now_ff;
         if (no_key) begin
            new_key = '0;
         end else if (hit_any) begin
            new_key = hit_key;
         end
      end
   end

   // Update tracking state at window end
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_avg_ff <= '0;
         rep_key_ff  <= '0;
         chg_time_ff <= '0;
      end else if (finish) begin
         prev_avg_ff <= avg;
         rep_key_ff  <= new_key;
         chg_time_ff <= new_time;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (finish) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         key_ff     <= new_key;
         changed_ff <= changed;
         held_ff    <= now_ff - new_time;
         avg_ff     <= AVG_W'(avg);
      end
   end

   assign out_valid   = valid_ff;
   assign out_key     = key_ff;
   assign out_changed = changed_ff;
   assign out_held_ms = held_ff;
   assign out_average = avg_ff;

   a_change_resets_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && changed_ff) |-> (held_ff == '0))
      else $error("changed result with nonzero hold time");

   a_key_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (int'(key_ff) < KEY_LEVELS))
      else $error("key beyond ladder levels");

   a_result_after_class: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff) |-> $past(state_ff == BK_CLASS))
      else $error("result raised outside classification");

endmodule

FILE: design/resistor_ladder_key_decoder.sv
// A window's result goes from the item that closes it through the queue, the serial
// divider (one quotient bit a cycle) and classification into the result register.
// One sample a cycle while the queue has room; the back end takes a window only
// when idle, with a two-entry queue between the sample front end and the divider.
// Reset (synchronous): clears window, tracking state and queue; registers return
// to sample_count 250 and threshold 5.
module resistor_ladder_key_decoder #(
   parameter int SAMPLE_BITS = rlkd_pkg::SAMPLE_BITS_DEF,
   parameter int KEY_LEVELS  = rlkd_pkg::KEY_LEVELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   rlkd_req_if.sink                        req,
   rlkd_rsp_if.source                      rsp,
   input  logic                            csr_we,
   input  logic [rlkd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rlkd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rlkd_pkg::*;

   localparam int SUM_W   = SAMPLE_BITS + COUNT_W;
   localparam int ENTRY_W = SUM_W + POS_W + TIME_W;

   logic [COUNT_W-1:0]  sample_count_ff;
   logic [THRESH_W-1:0] threshold_ff;

   logic               push, pop, full, empty;
   logic [ENTRY_W-1:0] push_data, pop_data;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= COUNT_W'(250);
         threshold_ff    <= THRESH_W'(5);
      end else if (csr_we) begin
         case (csr_index)
            CSR_SAMPLE_COUNT: sample_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_THRESHOLD:    threshold_ff    <= csr_wdata[THRESH_W-1:0];
            default: begin
               sample_count_ff <= sample_count_ff;
            end
         endcase
      end
   end

   rlkd_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_W       (SUM_W),
      .ENTRY_W     (ENTRY_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .sample_count (sample_count_ff),
      .in_valid     (req.valid),
      .in_ready     (req.ready),
      .in_sample    (req.sample),
      .in_now       (req.now_ms),
      .queue_full   (full),
      .push         (push),
      .push_data    (push_data)
   );

   rlkd_fifo #(
      .DATA_W (ENTRY_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (full),
      .empty     (empty)
   );

   rlkd_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .KEY_LEVELS  (KEY_LEVELS),
      .SUM_W       (SUM_W),
      .ENTRY_W     (ENTRY_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .threshold   (threshold_ff),
      .queue_empty (empty),
      .queue_data  (pop_data),
      .pop         (pop),
      .out_valid   (rsp.valid),
      .out_ready   (rsp.ready),
      .out_key     (rsp.key),
      .out_changed (rsp.changed),
      .out_held_ms (rsp.held_ms),
      .out_average (rsp.average)
   );

endmodule

FILE: tb/tb_top.sv
// Testbench for the resistor ladder key decoder: feeds ADC sample items, predicts the
// key report of every window and checks each report field by field.
// Depends on rlkd_pkg, the rlkd channel interfaces and resistor_ladder_key_decoder.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rlkd_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up
   localparam int DRAIN_CYCLES   = 40;    // settling time after the last report
   localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
   localparam int SAMPLE_MAX     = 1023;
   localparam int RESET_COUNT    = 250;
   localparam int RESET_THRESH   = 5;

   typedef struct packed {
      logic [9:0]        sample;
      logic [TIME_W-1:0] now_ms;
   } sample_item_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic              changed;
      logic [TIME_W-1:0] held_ms;
      logic [AVG_W-1:0]  average;
   } key_report_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rlkd_req_if req_ch ();
   rlkd_rsp_if rsp_ch ();

   resistor_ladder_key_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Stimulus and expectation stores
   sample_item_type pending_samples[$];
   key_report_type  expected_reports[$];
   sample_item_type current_sample;
   key_report_type  oldest_report;
   bit           in_flight;
   int           send_idle_pct;
   int           recv_idle_pct;
   bit           hold_arm;
   int           hold_left;

   // Decoder state as predicted
   logic [COUNT_W-1:0]  cfg_count;
   logic [THRESH_W-1:0] cfg_thresh;
   logic [19:0]         acc_sum;
   logic [POS_W-1:0]    win_pos;
   logic [AVG_W-1:0]    last_average;
   logic [KEY_W-1:0]    held_key;
   logic [TIME_W-1:0]   change_stamp;

   // Generator side window tracking and time base
   int          gen_pos;
   logic [31:0] clock_ms;
   int          last_target;
   int          pushed_total;

   // Run statistics
   int          mismatch_count;
   int          sample_total;
   int          report_total;
   int          change_total;
   int          stall_total;
   logic [31:0] keys_seen;

   // Directed window levels
   int plain_levels[8]  = '{1023, 968, 966, 515, 0, 978, 600, 984};
   int zero_th_levels[3] = '{968, 968, 1023};
   int wide_th_levels[2] = '{700, 515};

   function automatic bit within_band(input int x, input int centre, input int half);
      return x > centre - half && x < centre + half;
   endfunction

   // Advance the predicted window state by one accepted item; queue a report at window end
   task automatic decode_sample(input logic [9:0] s, input logic [TIME_W-1:0] now);
      int          n;
      int          avg;
      int          th;
      bit          moved;
      bit          found;
      key_report_type rep;
      if (win_pos == 0) begin
         win_pos = POS_W'(1);
         acc_sum = '0;
         return;
      end
      acc_sum = acc_sum + 20'(s);
      win_pos = win_pos + POS_W'(1);
      n = int'(win_pos) - 1;
      if (n < int'(cfg_count) + 1) return;
      avg = int'(acc_sum) / n;
      acc_sum = '0;
      win_pos = '0;
      th = int'(cfg_thresh);
      moved = !within_band(avg, int'(last_average), th);
      last_average = AVG_W'(avg);
      if (moved) begin
         // no key above the top level; otherwise the first matching level wins, else hold
         if (avg > int'(LADDER_LEVEL[0]) - th) begin
            held_key = '0;
         end else begin
            found = 1'b0;
            for (int k = 1; k < KEY_LEVELS_DEF; k++) begin
               if (!found && within_band(avg, int'(LADDER_LEVEL[k]), th)) begin
                  held_key = KEY_W'(k);
                  found = 1'b1;
               end
            end
         end
         change_stamp = now;
      end
      rep.key     = held_key;
      rep.changed = moved;
      rep.held_ms = now - change_stamp;
      rep.average = AVG_W'(avg);
      expected_reports.push_back(rep);
   endtask

   // Queue one sample item and follow where the window stands
   task automatic push_sample(input int value);
      if ($urandom_range(19) == 0) begin
         clock_ms = $urandom();
      end else begin
         clock_ms = clock_ms + $urandom_range(3);
      end
      pending_samples.push_back('{sample: 10'(value), now_ms: clock_ms});
      pushed_total++;
      if (gen_pos == 0) begin
         gen_pos = 1;
      end else begin
         gen_pos++;
         if (gen_pos - 1 >= int'(cfg_count) + 1) gen_pos = 0;
      end
   endtask

   // Queue items until the open window closes; the settling sample is always random
   task automatic push_window(input int target, input int jitter, input bit noisy);
      int value;
      do begin
         if (gen_pos == 0 || noisy) begin
            value = $urandom_range(SAMPLE_MAX);
         end else begin
            value = target + int'($urandom_range(2 * jitter)) - jitter;
         end
         value = (value < 0) ? 0 : (value > SAMPLE_MAX) ? SAMPLE_MAX : value;
         push_sample(value);
      end while (gen_pos != 0);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      if (index == CSR_SAMPLE_COUNT) begin
         cfg_count = data[COUNT_W-1:0];
      end else begin
         cfg_thresh = data[THRESH_W-1:0];
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait until every item is in and every report out, then let the back end settle
   task automatic drain_block();
      while (pending_samples.size() != 0 || in_flight || expected_reports.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One random setting followed by windows of random content
   task automatic run_phase(input int budget, input int force_count, input bit arm_hold);
      int pick;
      int count;
      int thresh;
      int target;
      int jitter;
      int start;
      pick = $urandom_range(99);
      if (force_count >= 0) begin
         count = force_count;
      end else if (pick < 60) begin
         count = $urandom_range(3);
      end else if (pick < 90) begin
         count = $urandom_range(20, 4);
      end else begin
         count = $urandom_range(60, 21);
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
         thresh = 0;
      end else if (pick < 20) begin
         thresh = 255;
      end else begin
         thresh = $urandom_range(12, 1);
      end
      write_register(CSR_SAMPLE_COUNT, CSR_DATA_W'(count));
      write_register(CSR_THRESHOLD, {2'($urandom_range(3)), 8'(thresh)});
      hold_arm = arm_hold;
      start = pushed_total;
      target = last_target;
      while (pushed_total - start < budget) begin
         pick = $urandom_range(99);
         jitter = 1;
         if (pick < 45) begin
            target = LADDER_LEVEL[$urandom_range(31, 1)];
         end else if (pick < 65) begin
            target = last_target;
         end else if (pick < 75) begin
            target = $urandom_range(SAMPLE_MAX, 975);
            jitter = 2;
         end else if (pick < 88) begin
            target = $urandom_range(SAMPLE_MAX);
            jitter = 3;
         end
         push_window(target, jitter, pick >= 88);
         last_target = target;
      end
      // leave a window open now and then, so the next setting lands mid-window
      if ($urandom_range(2) == 0) begin
         repeat ($urandom_range(count + 1, 1)) push_sample($urandom_range(SAMPLE_MAX));
      end
      drain_block();
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Sample driver: hold an item until it is taken, idle only between items
   always @(negedge clock) begin
      if (reset) begin
         in_flight = 1'b0;
      end else if (!in_flight && pending_samples.size() != 0
                   && $urandom_range(99) >= send_idle_pct) begin
         current_sample = pending_samples.pop_front();
         in_flight = 1'b1;
      end
      req_ch.valid  <= in_flight;
      req_ch.sample <= current_sample.sample;
      req_ch.now_ms <= current_sample.now_ms;
   end

   // Report receiver: random stalls, plus one long hold-off when armed
   always @(negedge clock) begin
      if (hold_arm) begin
         hold_arm = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Predict on every accepted item, check every accepted report
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         in_flight = 1'b0;
         sample_total++;
         decode_sample(req_ch.sample, req_ch.now_ms);
      end
      if (!reset && req_ch.valid && !req_ch.ready) stall_total++;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         report_total++;
         if (rsp_ch.changed === 1'b1) change_total++;
         keys_seen[rsp_ch.key] = 1'b1;
         if (expected_reports.size() == 0) begin
            $error("unexpected key report: key %0d average %0d", rsp_ch.key, rsp_ch.average);
            mismatch_count++;
         end else begin
            oldest_report = expected_reports.pop_front();
            if (rsp_ch.key !== oldest_report.key) begin
               $error("key: expected %0d, got %0d", oldest_report.key, rsp_ch.key);
               mismatch_count++;
            end
            if (rsp_ch.changed !== oldest_report.changed) begin
               $error("changed: expected %0d, got %0d", oldest_report.changed,
                      rsp_ch.changed);
               mismatch_count++;
            end
            if (rsp_ch.held_ms !== oldest_report.held_ms) begin
               $error("held_ms: expected %0d, got %0d", oldest_report.held_ms,
                      rsp_ch.held_ms);
               mismatch_count++;
            end
            if (rsp_ch.average !== oldest_report.average) begin
               $error("average: expected %0d, got %0d", oldest_report.average,
                      rsp_ch.average);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: give up after a long stretch with no item moving either way
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("tb_top: FAIL");
      $finish;
   end

   // Main sequence
   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_SAMPLE_COUNT;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.sample  = '0;
      req_ch.now_ms  = '0;
      rsp_ch.ready   = 1'b0;
      current_sample = '0;
      in_flight      = 1'b0;
      hold_arm       = 1'b0;
      hold_left      = 0;
      send_idle_pct  = 38;
      recv_idle_pct  = 79;
      cfg_count      = COUNT_W'(RESET_COUNT);
      cfg_thresh     = THRESH_W'(RESET_THRESH);
      acc_sum        = '0;
      win_pos        = '0;
      last_average   = '0;
      held_key       = '0;
      change_stamp   = '0;
      gen_pos        = 0;
      clock_ms       = 32'hFFFF_FF00;
      last_target    = LADDER_LEVEL[3];
      pushed_total   = 0;
      mismatch_count = 0;
      sample_total   = 0;
      report_total   = 0;
      change_total   = 0;
      stall_total    = 0;
      keys_seen      = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one window at the settings out of reset
      push_window(LADDER_LEVEL[7], 2, 1'b0);
      drain_block();

      // directed: single-sample windows across the ladder, both ends and the gaps
      write_register(CSR_SAMPLE_COUNT, '0);
      write_register(CSR_THRESHOLD, CSR_DATA_W'(RESET_THRESH));
      foreach (plain_levels[i]) push_window(plain_levels[i], 0, 1'b0);
      drain_block();
      // zero threshold: every window moves, no level can match
      write_register(CSR_THRESHOLD, '0);
      foreach (zero_th_levels[i]) push_window(zero_th_levels[i], 0, 1'b0);
      drain_block();
      // widest threshold, written with the spare data bits set
      write_register(CSR_THRESHOLD, '1);
      foreach (wide_th_levels[i]) push_window(wide_th_levels[i], 0, 1'b0);
      drain_block();

      // random phases under each idling pattern
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 38 : (mode == 1) ? 79 : 0;
         recv_idle_pct = (mode == 0) ? 79 : (mode == 1) ? 38 : 0;
         if (mode == 2) run_phase(50, 0, 1'b1);
         for (int p = 0; p < 5; p++) run_phase(40, -1, 1'b0);
      end

      $display("run summary: %0d sample items, %0d key reports, %0d of them changes",
               sample_total, report_total, change_total);
      $display("run summary: %0d distinct keys reported, %0d cycles of input held off",
               $countones(keys_seen), stall_total);
      if (mismatch_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
design/rlkd_pkg.sv
design/rlkd_if.sv
design/rlkd_front.sv
design/rlkd_fifo.sv
design/rlkd_back.sv
design/resistor_ladder_key_decoder.sv
tb/tb_top.sv
